// File: rtl/wsg_pkg.sv
package wsg_pkg;

   localparam int WAVE_BITS     = 3;
   localparam int PULSE_BITS    = 16;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   // Shape codes held in the wave_type register
   localparam logic [WAVE_BITS-1:0] WAVE_SINE     = 3'd0;
   localparam logic [WAVE_BITS-1:0] WAVE_COSINE   = 3'd1;
   localparam logic [WAVE_BITS-1:0] WAVE_RAMP     = 3'd2;
   localparam logic [WAVE_BITS-1:0] WAVE_SAW_UP   = 3'd3;
   localparam logic [WAVE_BITS-1:0] WAVE_SAW_DOWN = 3'd4;
   localparam logic [WAVE_BITS-1:0] WAVE_TRIANGLE = 3'd5;
   localparam logic [WAVE_BITS-1:0] WAVE_SQUARE   = 3'd6;
   localparam logic [WAVE_BITS-1:0] WAVE_ZERO     = 3'd7;

   // Register select, taken from paddr[2]
   localparam logic REG_WAVE_TYPE   = 1'b0;
   localparam logic REG_PULSE_WIDTH = 1'b1;

   localparam logic [WAVE_BITS-1:0]  WAVE_TYPE_RESET   = WAVE_SINE;
   localparam logic [PULSE_BITS-1:0] PULSE_WIDTH_RESET = 16'h8000;

   // One full cycle in 0.32 phase units, with room for the value 2^32 itself
   localparam int          SPAN_BITS = 33;
   localparam logic [32:0] SPAN      = 33'h1_0000_0000;

   // Register stages of the sine lookup
   localparam int SINE_STAGES = 4;

   typedef struct packed {
      logic [WAVE_BITS-1:0]  wave_type;
      logic [PULSE_BITS-1:0] pulse_width;
   } cfg_type;

endpackage

// File: rtl/wsg_csr.sv
module wsg_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wsg_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [wsg_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [wsg_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready,
   output wsg_pkg::cfg_type                    cfg
);
   import wsg_pkg::*;

   logic [WAVE_BITS-1:0]  wave_type_ff, wave_type_in;
   logic [PULSE_BITS-1:0] pulse_width_ff, pulse_width_in;
   logic                  write_en;

   assign csr_pready = 1'b1;
   assign write_en   = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      wave_type_in   = wave_type_ff;
      pulse_width_in = pulse_width_ff;
      if (write_en) begin
         unique case (csr_paddr[2])
            REG_WAVE_TYPE:   wave_type_in   = csr_pwdata[WAVE_BITS-1:0];
            REG_PULSE_WIDTH: pulse_width_in = csr_pwdata[PULSE_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wave_type_ff   <= WAVE_TYPE_RESET;
         pulse_width_ff <= PULSE_WIDTH_RESET;
      end else begin
         wave_type_ff   <= wave_type_in;
         pulse_width_ff <= pulse_width_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_WAVE_TYPE:   csr_prdata = CSR_DATA_BITS'(wave_type_ff);
         REG_PULSE_WIDTH: csr_prdata = CSR_DATA_BITS'(pulse_width_ff);
      endcase
   end

   assign cfg.wave_type   = wave_type_ff;
   assign cfg.pulse_width = pulse_width_ff;

endmodule

// File: rtl/wsg_sine.sv
module wsg_sine #(
   parameter int SAMPLE_BITS      = 16,
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  logic                               clock,
   input  logic [wsg_pkg::SINE_STAGES-1:0]    en,
   input  logic [31:0]                        p32,
   input  logic                               shift_quarter,
   output logic [SAMPLE_BITS-1:0]             sample
);
   import wsg_pkg::*;

   localparam int ADDR_BITS = $clog2(SINE_TABLE_DEPTH + 1);
   localparam int PROD_BITS = 30 + ADDR_BITS;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned ROM_MAX     = (64'd1 << (SAMPLE_BITS - 1)) - 64'd1;
   localparam longint unsigned TAYLOR_DIV [1:10] =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

   typedef logic [SAMPLE_BITS-2:0] rom_type [SINE_TABLE_DEPTH+1];

   // Quarter wave, sin(pi/2 * i/DEPTH) by an eleven-term series in Q30, rounded half up
   function automatic rom_type build_rom();
      rom_type         rom;
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned v;
      for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
         x    = HALF_PI_Q30 * longint'(i) / SINE_TABLE_DEPTH;
         x2   = (x * x) >> 30;
         term = x;
         sum  = x;
         for (int k = 1; k <= 10; k++) begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[k];
            if (k[0])
               sum = sum - term;
            else
               sum = sum + term;
         end
         v = ((sum << (SAMPLE_BITS - 1)) + (64'd1 << 29)) >> 30;
         if (v > ROM_MAX)
            v = ROM_MAX;
         rom[i] = v[SAMPLE_BITS-2:0];
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_rom();

   logic [1:0]             quad_in;
   logic [PROD_BITS-1:0]   prod_in;
   logic [1:0]             quad_s2_ff;
   logic [PROD_BITS-1:0]   prod_s2_ff;
   logic [ADDR_BITS-1:0]   idx;
   logic [ADDR_BITS-1:0]   addr_in;
   logic [ADDR_BITS-1:0]   addr_s3_ff;
   logic                   neg_s3_ff;
   logic [SAMPLE_BITS-2:0] rom_s4_ff;
   logic                   neg_s4_ff;
   logic [SAMPLE_BITS-1:0] sample_ff;

   assign quad_in = p32[31:30] + {1'b0, shift_quarter};
   assign prod_in = PROD_BITS'(p32[29:0]) * PROD_BITS'(SINE_TABLE_DEPTH);

   // Mirror the index on the falling quarters
   assign idx     = prod_s2_ff[PROD_BITS-1:30];
   assign addr_in = quad_s2_ff[0] ? (ADDR_BITS'(SINE_TABLE_DEPTH) - idx) : idx;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         quad_s2_ff <= quad_in;
         prod_s2_ff <= prod_in;
      end
      if (en[1]) begin
         addr_s3_ff <= addr_in;
         neg_s3_ff  <= quad_s2_ff[1];
      end
      if (en[2]) begin
         rom_s4_ff <= SINE_ROM[addr_s3_ff];
         neg_s4_ff <= neg_s3_ff;
      end
      if (en[3]) begin
         sample_ff <= neg_s4_ff ? -{1'b0, rom_s4_ff} : {1'b0, rom_s4_ff};
      end
   end

   assign sample = sample_ff;

endmodule

// File: rtl/wsg_div.sv
module wsg_div #(
   parameter int QUO_BITS = 17
) (
   input  logic                              clock,
   input  logic [QUO_BITS:0]                 en,
   input  logic [wsg_pkg::SPAN_BITS-1:0]     num,
   input  logic [wsg_pkg::SPAN_BITS-1:0]     den,
   output logic [QUO_BITS-1:0]               quo
);
   import wsg_pkg::*;

   // Restoring division of num * 2^(QUO_BITS-1) by den, num <= den, one bit a stage
   logic [SPAN_BITS-1:0] rem_ff   [QUO_BITS];
   logic [SPAN_BITS-1:0] den_ff   [QUO_BITS];
   logic [QUO_BITS-1:0]  quo_ff   [1:QUO_BITS];
   logic [SPAN_BITS:0]   trial    [QUO_BITS];
   logic                 ge       [QUO_BITS];
   logic [SPAN_BITS-1:0] rem_in   [QUO_BITS-1];

   always_comb begin
      for (int j = 0; j < QUO_BITS; j++) begin
         trial[j] = (j == 0) ? {1'b0, rem_ff[j]} : {rem_ff[j], 1'b0};
         ge[j]    = trial[j] >= {1'b0, den_ff[j]};
      end
      for (int j = 0; j < QUO_BITS - 1; j++) begin
         rem_in[j] = ge[j] ? SPAN_BITS'(trial[j] - {1'b0, den_ff[j]})
                           : trial[j][SPAN_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         rem_ff[0] <= num;
         den_ff[0] <= den;
      end
      if (en[1])
         quo_ff[1] <= QUO_BITS'(ge[0]);
      for (int j = 1; j < QUO_BITS; j++) begin
         if (en[j]) begin
            rem_ff[j] <= rem_in[j-1];
            den_ff[j] <= den_ff[j-1];
         end
         if (en[j+1])
            quo_ff[j+1] <= {quo_ff[j][QUO_BITS-2:0], ge[j]};
      end
   end

   assign quo = quo_ff[QUO_BITS];

endmodule

// File: rtl/waveform_shape_generator.sv
// Depth: an item runs through the input register, the operand stage, one triangle
// divider stage per quotient bit and the output register on its way to rsp_tvalid.
// Throughput: one item per cycle; a stalled output holds, and upstream stages keep
// filling bubbles, so the input stalls only when every stage is full.
// Reset: synchronous, clears all stage valid bits and loads wave_type 0 (sine) and
// pulse_width 0x8000; the sine table is a constant ROM and needs no fill.
module waveform_shape_generator #(
   parameter int PHASE_BITS       = 16,
   parameter int SAMPLE_BITS      = 16,
   parameter int SINE_TABLE_DEPTH = 1024,
   localparam int REQ_DATA_BITS   = ((PHASE_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS   = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [REQ_DATA_BITS-1:0]            req_tdata,   // [PHASE_BITS-1:0] phase
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [RSP_DATA_BITS-1:0]            rsp_tdata,   // [SAMPLE_BITS-1:0] sample
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wsg_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [wsg_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [wsg_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);
   import wsg_pkg::*;

   // Stage map: 1 input register; 2 operands (divider, sine product, simple shapes);
   // sine result at SINE_OUT_STAGE; quotient at DIV_OUT_STAGE; LAST_STAGE output register.
   localparam int QUO_BITS       = SAMPLE_BITS + 1;
   localparam int DIV_OUT_STAGE  = 2 + QUO_BITS;
   localparam int LAST_STAGE     = DIV_OUT_STAGE + 1;
   localparam int SINE_OUT_STAGE = 1 + SINE_STAGES;

   localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   cfg_type cfg;

   wsg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // ---------------------------------------------------------------------
   // Flow control: a stage may load when it or any stage below it is empty, or
   // when the output is taken. Each ready is a reduction over the downstream valid
   // bits, so bubbles collapse and a waiting result does not block the input.
   // ---------------------------------------------------------------------
   logic [LAST_STAGE:1] valid_ff;
   logic [LAST_STAGE:1] valid_in;
   logic [LAST_STAGE:1] ready;

   for (genvar i = 1; i <= LAST_STAGE; i++) begin : g_ready
      assign ready[i] = rsp_tready || !(&valid_ff[LAST_STAGE:i]);
   end

   assign valid_in = {valid_ff[LAST_STAGE-1:1], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         // advance where ready, hold elsewhere
         valid_ff <= (valid_in & ready) | (valid_ff & ~ready);
      end
   end

   assign req_tready = ready[1];
   assign rsp_tvalid = valid_ff[LAST_STAGE];

   // ---------------------------------------------------------------------
   // Stage 1: capture the phase
   // ---------------------------------------------------------------------
   logic [PHASE_BITS-1:0] phase_s1_ff;

   always_ff @(posedge clock) begin
      if (ready[1])
         phase_s1_ff <= req_tdata[PHASE_BITS-1:0];
   end

   // Widen to a 0.32 fraction; the pulse width is a 0.16 fraction
   logic [31:0]            p32;
   logic [31:0]            w32;
   logic [SAMPLE_BITS-1:0] top_bits;
   logic [SAMPLE_BITS-1:0] simple_in;
   logic                   rising;
   logic [SPAN_BITS-1:0]   div_num;
   logic [SPAN_BITS-1:0]   div_den;
   logic                   sine_sel;
   logic                   tri_sel;

   assign p32      = 32'(phase_s1_ff) << (32 - PHASE_BITS);
   assign w32      = {cfg.pulse_width, 16'b0};
   assign top_bits = p32[31:32-SAMPLE_BITS];

   assign sine_sel = (cfg.wave_type == WAVE_SINE) || (cfg.wave_type == WAVE_COSINE);
   assign tri_sel  = (cfg.wave_type == WAVE_TRIANGLE);

   // Shapes that need no table and no division; sine, cosine and triangle are
   // merged in further down, and the zero shape stays 0.
   always_comb begin
      unique case (cfg.wave_type)
         WAVE_RAMP:     simple_in = SAMPLE_BITS'(p32[31:33-SAMPLE_BITS]);
         // subtract one by flipping the top bit
         WAVE_SAW_UP:   simple_in = {~top_bits[SAMPLE_BITS-1], top_bits[SAMPLE_BITS-2:0]};
         // two minus the fraction: the whole first half lands at or above +1.0
         WAVE_SAW_DOWN: simple_in = (top_bits <= SAMPLE_ONE) ? SAMPLE_MAX : -top_bits;
         WAVE_SQUARE:   simple_in = (p32 >= w32) ? SAMPLE_ONE : SAMPLE_MAX;
         default:       simple_in = '0;
      endcase
   end

   // Triangle operands: rising branch p/w, falling branch (1-p)/(1-w).
   // A zero pulse width always falls, so the divisor never reaches zero.
   assign rising  = p32 < w32;
   assign div_num = rising ? {1'b0, p32} : SPAN - {1'b0, p32};
   assign div_den = rising ? {1'b0, w32} : SPAN - {1'b0, w32};

   // ---------------------------------------------------------------------
   // Triangle divider: stages 2 .. DIV_OUT_STAGE
   // ---------------------------------------------------------------------
   logic [QUO_BITS-1:0] quo;

   wsg_div #(
      .QUO_BITS (QUO_BITS)
   ) u_div (
      .clock (clock),
      .en    (ready[DIV_OUT_STAGE:2]),
      .num   (div_num),
      .den   (div_den),
      .quo   (quo)
   );

   // ---------------------------------------------------------------------
   // Sine lookup: stages 2 .. SINE_OUT_STAGE; cosine is a quarter turn ahead
   // ---------------------------------------------------------------------
   logic [SAMPLE_BITS-1:0] sine_sample;

   wsg_sine #(
      .SAMPLE_BITS      (SAMPLE_BITS),
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sine (
      .clock         (clock),
      .en            (ready[SINE_OUT_STAGE:2]),
      .p32           (p32),
      .shift_quarter (cfg.wave_type == WAVE_COSINE),
      .sample        (sine_sample)
   );

   // ---------------------------------------------------------------------
   // Side line: carry the simple shape down to the divider output; swap in
   // the sine result right after the sine unit delivers it.
   // ---------------------------------------------------------------------
   logic [SAMPLE_BITS-1:0] side_ff [2:DIV_OUT_STAGE];

   always_ff @(posedge clock) begin
      if (ready[2])
         side_ff[2] <= simple_in;
      for (int k = 3; k <= DIV_OUT_STAGE; k++) begin
         if (ready[k])
            side_ff[k] <= ((k == SINE_OUT_STAGE + 1) && sine_sel) ? sine_sample
                                                                  : side_ff[k-1];
      end
   end

   // ---------------------------------------------------------------------
   // Output stage: quotient minus one, a full quotient (+1.0) saturates
   // ---------------------------------------------------------------------
   logic [SAMPLE_BITS-1:0] tri_sample;
   logic [SAMPLE_BITS-1:0] sample_ff;

   assign tri_sample = quo[QUO_BITS-1] ? SAMPLE_MAX
                                       : {~quo[SAMPLE_BITS-1], quo[SAMPLE_BITS-2:0]};

   always_ff @(posedge clock) begin
      if (ready[LAST_STAGE])
         sample_ff <= tri_sel ? tri_sample : side_ff[DIV_OUT_STAGE];
   end

   assign rsp_tdata = RSP_DATA_BITS'(sample_ff);

endmodule

// File: rtl/wsg_checker.sv
module wsg_checker #(
   parameter int PHASE_BITS     = 16,
   parameter int SAMPLE_BITS    = 16,
   localparam int REQ_DATA_BITS = ((PHASE_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [REQ_DATA_BITS-1:0]            req_tdata,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [RSP_DATA_BITS-1:0]            rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wsg_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [wsg_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   input  logic [wsg_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   input  logic                                csr_pready
);
   import wsg_pkg::*;

   logic wave_write;

   assign wave_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_WAVE_TYPE);

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // A free output stage means some stage has room, so the input must be open
   a_input_open: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled with a free pipeline");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("stalled result changed");

   // A wave_type write reads back masked to its width
   a_wave_readback: assert property (@(posedge clock)
      ($past(wave_write && !reset) && (csr_paddr[2] == REG_WAVE_TYPE))
         |-> (csr_prdata == CSR_DATA_BITS'($past(csr_pwdata[WAVE_BITS-1:0]))))
      else $error("wave_type read back differs from the value written");

endmodule

bind waveform_shape_generator wsg_checker #(
   .PHASE_BITS  (PHASE_BITS),
   .SAMPLE_BITS (SAMPLE_BITS)
) u_wsg_checker (.*);
